@@ design/vrra_pkg.sv @@
// Shared types, constants and helpers of the variable record ring allocator.
package vrra_pkg;

	localparam int REGION_BYTES = 4096;
	localparam int ALIGN_BYTES  = 8;
	localparam int HEADER_BYTES = 48;
	localparam int SLOTS        = (REGION_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
	localparam int IDX_W        = $clog2(SLOTS);
	localparam int LINK_W       = IDX_W + 1;
	localparam int ALIGN_LG     = $clog2(ALIGN_BYTES);
	localparam int LEN_W        = 13;
	localparam int HND_W        = 12;
	localparam int CNT_W        = 10;
	localparam int CAP_W        = 13;
	localparam int OFF_W        = 16;

	localparam int unsigned REG_CAPACITY = 0;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [LINK_W-1:0] link_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [HND_W-1:0]  hnd_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [CAP_W-1:0]  cap_t;
	typedef logic [OFF_W-1:0]  off_t;

	localparam link_t LINK_NIL = '1;

	typedef enum logic [1:0] {
		ST_FREE,
		ST_WRITING,
		ST_COMMITTED,
		ST_READING
	} ent_st_t;

	typedef enum logic [1:0] {
		KIND_RESERVE,
		KIND_CONSUME,
		KIND_COMMIT
	} kind_t;

	typedef enum logic [2:0] {
		STS_OK,
		STS_NO_ROOM,
		STS_EMPTY,
		STS_BLOCKED,
		STS_BAD_HANDLE
	} sts_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH,
		S_RS_H, S_RS_D, S_INS_E, S_INS_F, S_INS_H,
		S_MS_FREE, S_MS_W,
		S_RC_START, S_RC_U, S_RC_B, S_RC_SPAN, S_RC_N, S_RF,
		S_RW_NE, S_RW_EN, S_RW_B, S_RW_SO, S_RW_EW, S_RW_AP,
		S_CS_RD,
		S_CM_RD, S_CM_NW, S_CM_UR,
		S_RM_F, S_RM_P, S_RM_N, S_RM_O, S_RM_W,
		S_DONE
	} fsm_t;

	typedef struct packed {
		idx_t    next;
		idx_t    prev;
		link_t   newer;
		link_t   older;
		ent_st_t status;
		len_t    length;
	} entry_t;

	typedef struct packed {
		logic next;
		logic prev;
		logic newer;
		logic older;
		logic status;
		logic length;
	} fmask_t;

	typedef struct packed {
		fmask_t mask;
		idx_t   addr;
		entry_t data;
	} wr_t;

	typedef struct packed {
		logic [1:0] kind;
		len_t       len;
		logic       over;
		logic       disc;
		logic       aband;
		hnd_t       handle;
	} item_t;

	typedef struct packed {
		sts_t status;
		hnd_t handle;
		len_t length;
		cnt_t wc;
		cnt_t cc;
		cnt_t rc;
	} res_t;

	function automatic off_t slot_cost(len_t len);
		off_t t;
		t = OFF_W'(HEADER_BYTES) + OFF_W'(len) + OFF_W'(ALIGN_BYTES - 1);
		return t & ~OFF_W'(ALIGN_BYTES - 1);
	endfunction

	function automatic off_t offset_of(idx_t e);
		return OFF_W'(e) << ALIGN_LG;
	endfunction

	function automatic idx_t idx_of(off_t o);
		return IDX_W'(o >> ALIGN_LG);
	endfunction

	function automatic logic is_nil(link_t l);
		return l[LINK_W-1];
	endfunction

	function automatic link_t to_link(idx_t e);
		return {1'b0, e};
	endfunction

endpackage

@@ design/variable_record_ring_allocator.sv @@
// Top level: stream ports, capacity register, output register and sequencer.
//
// Input beats on s_* carry one operation: s_tuser is the kind (reserve,
// consume, commit), s_tdata the length, flags and handle. Each accepted beat
// yields exactly one result beat on m_* with status, record handle, record
// length and the writing, committed and reading counts after the operation.
// One operation runs at a time on a sequencer that shares one read and one
// write port of the entry table; s_tready is high only while it is idle.
// A reserve that reclaims old records walks them and frees each one on the
// single table port, or frees the only record directly. The result beat
// appears in the same cycle in which the next input beat can be taken.
// The result sits in an output register, so a new beat is taken while an
// earlier result still waits; a stalled m_tready holds the result and only
// the next completion waits for it.
// Reset empties the lists and clears the counts at once; the entry table
// itself is not swept. capacity_bytes sits at byte address 0 of the register
// port and resets to 4096.
module variable_record_ring_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // data_length, allow_overwrite, discard, abandon, handle
	input  logic [1:0]  s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // status, record_handle, record_length,
	                              // writing_count, committed_count, reading_count
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import vrra_pkg::*;

	cap_t   cap_q;
	item_t  item;
	res_t   result;
	logic   res_valid, res_ready;
	idx_t   rd_addr;
	entry_t rd_data;
	wr_t    wr;
	logic   m_tvalid_q;
	logic [63:0] m_tdata_q;

	assign pready = 1'b1;
	assign prdata = (32'(paddr[2]) == REG_CAPACITY) ? 32'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && (32'(paddr[2]) == REG_CAPACITY)) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign item = '{kind: s_tuser, len: s_tdata[12:0], over: s_tdata[13],
		disc: s_tdata[14], aband: s_tdata[15], handle: s_tdata[27:16]};

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_tdata_q <= {6'b0, result.rc, result.cc, result.wc, result.length,
				result.handle, result.status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	vrra_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.item      (item),
		.cap       (cap_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.result    (result),
		.rd_addr   (rd_addr),
		.rd        (rd_data),
		.wr        (wr)
	);

	vrra_table u_table (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr      (wr)
	);

endmodule

@@ design/vrra_table.sv @@
// Entry table memories: links, status and length, one read and one write port.
module vrra_table (
	input  logic            clk,
	input  vrra_pkg::idx_t  rd_addr,
	output vrra_pkg::entry_t rd_data,
	input  vrra_pkg::wr_t   wr
);
	import vrra_pkg::*;

	idx_t    mem_next   [SLOTS];
	idx_t    mem_prev   [SLOTS];
	link_t   mem_newer  [SLOTS];
	link_t   mem_older  [SLOTS];
	ent_st_t mem_status [SLOTS];
	len_t    mem_length [SLOTS];
	entry_t  rd_q;
	logic    hit;

	assign hit = (wr.addr == rd_addr);
	assign rd_data = rd_q;

	always_ff @(posedge clk) begin
		if (wr.mask.next)   mem_next[wr.addr]   <= wr.data.next;
		if (wr.mask.prev)   mem_prev[wr.addr]   <= wr.data.prev;
		if (wr.mask.newer)  mem_newer[wr.addr]  <= wr.data.newer;
		if (wr.mask.older)  mem_older[wr.addr]  <= wr.data.older;
		if (wr.mask.status) mem_status[wr.addr] <= wr.data.status;
		if (wr.mask.length) mem_length[wr.addr] <= wr.data.length;
		rd_q.next   <= (wr.mask.next && hit)   ? wr.data.next   : mem_next[rd_addr];
		rd_q.prev   <= (wr.mask.prev && hit)   ? wr.data.prev   : mem_prev[rd_addr];
		rd_q.newer  <= (wr.mask.newer && hit)  ? wr.data.newer  : mem_newer[rd_addr];
		rd_q.older  <= (wr.mask.older && hit)  ? wr.data.older  : mem_older[rd_addr];
		rd_q.status <= (wr.mask.status && hit) ? wr.data.status : mem_status[rd_addr];
		rd_q.length <= (wr.mask.length && hit) ? wr.data.length : mem_length[rd_addr];
	end

endmodule

@@ design/vrra_seq.sv @@
// Operation sequencer: reserve, reclaim, consume and commit over the entry table.
module vrra_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  vrra_pkg::item_t  item,
	input  vrra_pkg::cap_t   cap,
	output logic             res_valid,
	input  logic             res_ready,
	output vrra_pkg::res_t   result,
	output vrra_pkg::idx_t   rd_addr,
	input  vrra_pkg::entry_t rd,
	output vrra_pkg::wr_t    wr
);
	import vrra_pkg::*;

	fsm_t  state_q, state_d;
	item_t item_q;
	off_t  need_q, np_q, start_q, span_q;
	idx_t  e_q, h_q, f_q, u_q, k_q, end_q, end_next_q;
	len_t  end_len_q;
	link_t end_newer_q, s_older_q, nw_q, od_q;
	cnt_t  lost_q, cnt_q;
	sts_t  sts_q;
	hnd_t  rh_q;
	len_t  rl_q;
	link_t newest_q, oldest_q, unread_q;
	cnt_t  wc_q, cc_q, rc_q;

	off_t  cap_use, off_f, gap, span_raw;
	logic  fwd, fit_gap, fit_tail, fit_head, rs_place, rc_cont, wrap, cm_bad;
	idx_t  rs_idx;
	link_t newest1;
	sts_t  disp_sts;

	function automatic cnt_t cnt_dec(cnt_t v);
		return (v != '0) ? v - 1'b1 : '0;
	endfunction

	always_comb begin
		cap_use  = (OFF_W'(cap) > OFF_W'(REGION_BYTES)) ? OFF_W'(REGION_BYTES) : OFF_W'(cap);
		off_f    = offset_of(f_q);
		fwd      = f_q > h_q;
		gap      = (off_f > np_q) ? off_f - np_q : '0;
		fit_gap  = gap >= need_q;
		fit_tail = (cap_use >= np_q) && ((cap_use - np_q) >= need_q);
		fit_head = off_f >= need_q;
		rs_place = fwd ? fit_gap : (fit_tail || fit_head);
		rs_idx   = (fwd || fit_tail) ? idx_of(np_q) : '0;
		span_raw = offset_of(end_q) + slot_cost(end_len_q);
		rc_cont  = (span_q < need_q) && (rd.status == ST_COMMITTED) &&
			(to_link(end_next_q) == end_newer_q) && (end_next_q > end_q);
		wrap     = end_next_q == u_q;
		newest1  = is_nil(end_newer_q) ? s_older_q : newest_q;
		cm_bad   = (rd.status == ST_FREE) || (rd.status == ST_COMMITTED);
		disp_sts = STS_OK;
		case (item_q.kind)
			KIND_RESERVE: if (is_nil(oldest_q) && (need_q > cap_use)) disp_sts = STS_NO_ROOM;
			KIND_CONSUME: if (is_nil(unread_q)) disp_sts = STS_EMPTY;
			KIND_COMMIT: begin
				if (item_q.handle[ALIGN_LG-1:0] != '0) disp_sts = STS_BAD_HANDLE;
			end
			default:      disp_sts = STS_OK;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (in_valid) state_d = S_DISPATCH;
			S_DISPATCH: begin
				case (item_q.kind)
					KIND_RESERVE: begin
						if (is_nil(oldest_q)) state_d = (need_q > cap_use) ? S_DONE : S_MS_W;
						else state_d = S_RS_H;
					end
					KIND_CONSUME: state_d = is_nil(unread_q) ? S_DONE : S_CS_RD;
					KIND_COMMIT:  state_d = (item_q.handle[ALIGN_LG-1:0] != '0) ? S_DONE : S_CM_RD;
					default:      state_d = S_DONE;
				endcase
			end
			S_RS_H:     state_d = S_RS_D;
			S_RS_D:     state_d = rs_place ? S_INS_E : (item_q.over ? S_RC_START : S_DONE);
			S_INS_E:    state_d = S_INS_F;
			S_INS_F:    state_d = S_INS_H;
			S_INS_H:    state_d = S_DONE;
			S_RC_START: state_d = is_nil(unread_q) ? S_DONE : S_RC_U;
			S_RC_U: begin
				if (rd.status != ST_COMMITTED) state_d = S_DONE;
				else if (rd.next == u_q) state_d = (cap_use < need_q) ? S_DONE : S_MS_FREE;
				else state_d = S_RC_B;
			end
			S_RC_B:     state_d = S_RC_SPAN;
			S_RC_SPAN:  state_d = S_RC_N;
			S_RC_N: begin
				if (rc_cont) state_d = S_RC_SPAN;
				else state_d = (span_q < need_q) ? S_DONE : S_RF;
			end
			S_RF:       if (cnt_q == CNT_W'(1)) state_d = S_RW_NE;
			S_RW_NE:    state_d = S_RW_EN;
			S_RW_EN:    state_d = S_RW_B;
			S_RW_B:     state_d = S_RW_SO;
			S_RW_SO:    state_d = S_RW_EW;
			S_RW_EW:    state_d = S_RW_AP;
			S_RW_AP:    state_d = S_DONE;
			S_MS_FREE:  state_d = S_MS_W;
			S_MS_W:     state_d = S_DONE;
			S_CS_RD:    state_d = S_DONE;
			S_CM_RD: begin
				if (cm_bad) state_d = S_DONE;
				else if (rd.status == ST_WRITING) state_d = item_q.disc ? S_RM_F : S_DONE;
				else if (!item_q.disc) state_d = S_RM_F;
				else state_d = is_nil(rd.newer) ? S_DONE : S_CM_NW;
			end
			S_CM_NW: begin
				if (rd.status == ST_READING) state_d = item_q.aband ? S_RM_F : S_DONE;
				else state_d = is_nil(unread_q) ? S_DONE : S_CM_UR;
			end
			S_CM_UR:    state_d = S_DONE;
			S_RM_F:     state_d = (f_q == e_q) ? S_DONE : S_RM_P;
			S_RM_P:     state_d = S_RM_N;
			S_RM_N:     state_d = S_RM_O;
			S_RM_O:     state_d = S_RM_W;
			S_RM_W:     state_d = S_DONE;
			S_DONE:     if (res_ready) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = state_q == S_IDLE;
		res_valid = state_q == S_DONE;
		result    = '{status: sts_q, handle: rh_q, length: rl_q, wc: wc_q, cc: cc_q, rc: rc_q};
		rd_addr   = e_q;
		wr        = '0;
		wr.addr   = e_q;
		case (state_q)
			S_DISPATCH: begin
				case (item_q.kind)
					KIND_RESERVE: rd_addr = newest_q[IDX_W-1:0];
					KIND_CONSUME: rd_addr = unread_q[IDX_W-1:0];
					default:      rd_addr = idx_of(OFF_W'(item_q.handle));
				endcase
			end
			S_INS_E: begin
				wr.mask = '1;
				wr.data = '{next: f_q, prev: h_q, newer: LINK_NIL, older: to_link(h_q),
					status: ST_WRITING, length: item_q.len};
			end
			S_INS_F: begin
				wr.addr = f_q;
				wr.mask.prev = 1'b1;
				wr.data.prev = e_q;
			end
			S_INS_H: begin
				wr.addr = h_q;
				wr.mask.next = 1'b1;
				wr.mask.newer = 1'b1;
				wr.data.next = e_q;
				wr.data.newer = to_link(e_q);
			end
			S_RC_START: rd_addr = unread_q[IDX_W-1:0];
			S_RC_U:     rd_addr = rd.prev;
			S_RC_SPAN:  rd_addr = end_next_q;
			S_RC_N:     rd_addr = u_q;
			S_RF: begin
				rd_addr = rd.next;
				wr.addr = k_q;
				wr.mask.status = 1'b1;
				wr.data.status = ST_FREE;
			end
			S_RW_NE: begin
				wr.mask = '1;
				wr.data = '{next: wrap ? e_q : end_next_q, prev: wrap ? e_q : h_q,
					newer: LINK_NIL, older: newest1, status: ST_WRITING, length: item_q.len};
			end
			S_RW_EN: begin
				wr.addr = end_next_q;
				wr.mask.prev = !wrap;
				wr.data.prev = e_q;
			end
			S_RW_B: begin
				wr.addr = h_q;
				wr.mask.next = !wrap;
				wr.data.next = e_q;
			end
			S_RW_SO: begin
				wr.addr = s_older_q[IDX_W-1:0];
				wr.mask.newer = !is_nil(s_older_q);
				wr.data.newer = end_newer_q;
			end
			S_RW_EW: begin
				wr.addr = end_newer_q[IDX_W-1:0];
				wr.mask.older = !is_nil(end_newer_q);
				wr.data.older = s_older_q;
			end
			S_RW_AP: begin
				wr.addr = newest1[IDX_W-1:0];
				wr.mask.newer = !is_nil(newest1);
				wr.data.newer = to_link(e_q);
			end
			S_MS_FREE: begin
				wr.addr = u_q;
				wr.mask.status = 1'b1;
				wr.data.status = ST_FREE;
			end
			S_MS_W: begin
				wr.addr = '0;
				wr.mask = '1;
				wr.data = '{next: '0, prev: '0, newer: LINK_NIL, older: LINK_NIL,
					status: ST_WRITING, length: item_q.len};
			end
			S_CS_RD: begin
				wr.addr = unread_q[IDX_W-1:0];
				wr.mask.status = rd.status == ST_COMMITTED;
				wr.data.status = ST_READING;
			end
			S_CM_RD: begin
				rd_addr = rd.newer[IDX_W-1:0];
				wr.mask.status = !cm_bad && (((rd.status == ST_WRITING) && !item_q.disc) ||
					((rd.status == ST_READING) && item_q.disc && is_nil(rd.newer)));
				wr.data.status = ST_COMMITTED;
			end
			S_CM_NW: begin
				rd_addr = unread_q[IDX_W-1:0];
				wr.mask.status = rd.status != ST_READING;
				wr.data.status = ST_COMMITTED;
			end
			S_RM_F: begin
				wr.mask.status = 1'b1;
				wr.data.status = ST_FREE;
			end
			S_RM_P: begin
				wr.addr = h_q;
				wr.mask.next = 1'b1;
				wr.data.next = f_q;
			end
			S_RM_N: begin
				wr.addr = f_q;
				wr.mask.prev = 1'b1;
				wr.data.prev = h_q;
			end
			S_RM_O: begin
				wr.addr = od_q[IDX_W-1:0];
				wr.mask.newer = !is_nil(od_q);
				wr.data.newer = nw_q;
			end
			S_RM_W: begin
				wr.addr = nw_q[IDX_W-1:0];
				wr.mask.older = !is_nil(nw_q);
				wr.data.older = od_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			newest_q <= LINK_NIL;
			oldest_q <= LINK_NIL;
			unread_q <= LINK_NIL;
			wc_q     <= '0;
			cc_q     <= '0;
			rc_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q <= item;
						need_q <= slot_cost(item.len);
					end
				end
				S_DISPATCH: begin
					sts_q <= disp_sts;
					rh_q  <= '0;
					rl_q  <= '0;
					h_q   <= newest_q[IDX_W-1:0];
					e_q   <= (item_q.kind == KIND_RESERVE) ? '0 : idx_of(OFF_W'(item_q.handle));
				end
				S_RS_H: begin
					np_q <= offset_of(h_q) + slot_cost(rd.length);
					f_q  <= rd.next;
				end
				S_RS_D: begin
					if (rs_place) e_q <= rs_idx;
					else if (!item_q.over) sts_q <= STS_NO_ROOM;
				end
				S_INS_H: begin
					newest_q <= to_link(e_q);
					wc_q     <= wc_q + 1'b1;
					if (is_nil(unread_q)) unread_q <= to_link(e_q);
					rh_q     <= HND_W'(offset_of(e_q));
					rl_q     <= item_q.len;
				end
				S_RC_START: begin
					u_q <= unread_q[IDX_W-1:0];
					if (is_nil(unread_q)) sts_q <= STS_NO_ROOM;
				end
				S_RC_U: begin
					h_q         <= rd.prev;
					s_older_q   <= rd.older;
					end_q       <= u_q;
					end_len_q   <= rd.length;
					end_next_q  <= rd.next;
					end_newer_q <= rd.newer;
					lost_q      <= CNT_W'(1);
					if (rd.status != ST_COMMITTED) sts_q <= STS_NO_ROOM;
					else if ((rd.next == u_q) && (cap_use < need_q)) sts_q <= STS_NO_ROOM;
				end
				S_RC_B: begin
					start_q <= (h_q < u_q) ? offset_of(h_q) + slot_cost(rd.length) : '0;
				end
				S_RC_SPAN: begin
					span_q <= (span_raw > start_q) ? span_raw - start_q : '0;
				end
				S_RC_N: begin
					if (rc_cont) begin
						end_q       <= end_next_q;
						end_len_q   <= rd.length;
						end_next_q  <= rd.next;
						end_newer_q <= rd.newer;
						lost_q      <= lost_q + 1'b1;
					end else if (span_q < need_q) begin
						sts_q <= STS_NO_ROOM;
					end else begin
						k_q   <= u_q;
						cnt_q <= lost_q;
						e_q   <= idx_of(start_q);
					end
				end
				S_RF: begin
					k_q   <= rd.next;
					cnt_q <= cnt_q - 1'b1;
				end
				S_RW_AP: begin
					newest_q <= to_link(e_q);
					if (is_nil(s_older_q)) begin
						oldest_q <= is_nil(end_newer_q) ? to_link(e_q) : end_newer_q;
					end
					unread_q <= is_nil(end_newer_q) ? to_link(e_q) : end_newer_q;
					cc_q     <= (cc_q > lost_q) ? cc_q - lost_q : '0;
					wc_q     <= wc_q + 1'b1;
					rh_q     <= HND_W'(offset_of(e_q));
					rl_q     <= item_q.len;
				end
				S_MS_FREE: begin
					newest_q <= LINK_NIL;
					oldest_q <= LINK_NIL;
					unread_q <= LINK_NIL;
					wc_q     <= '0;
					cc_q     <= '0;
					rc_q     <= '0;
				end
				S_MS_W: begin
					newest_q <= '0;
					oldest_q <= '0;
					unread_q <= '0;
					wc_q     <= wc_q + 1'b1;
					rh_q     <= '0;
					rl_q     <= item_q.len;
				end
				S_CS_RD: begin
					if (rd.status != ST_COMMITTED) begin
						sts_q <= STS_EMPTY;
					end else begin
						cc_q     <= cnt_dec(cc_q);
						rc_q     <= rc_q + 1'b1;
						unread_q <= rd.newer;
						rh_q     <= HND_W'(offset_of(unread_q[IDX_W-1:0]));
						rl_q     <= rd.length;
					end
				end
				S_CM_RD: begin
					if (cm_bad) begin
						sts_q <= STS_BAD_HANDLE;
					end else begin
						rh_q <= item_q.handle;
						rl_q <= rd.length;
						f_q  <= rd.next;
						h_q  <= rd.prev;
						nw_q <= rd.newer;
						od_q <= rd.older;
						if (rd.status == ST_WRITING) begin
							wc_q <= cnt_dec(wc_q);
							if (!item_q.disc) cc_q <= cc_q + 1'b1;
						end else if (!item_q.disc) begin
							rc_q <= cnt_dec(rc_q);
						end else if (is_nil(rd.newer)) begin
							rc_q     <= cnt_dec(rc_q);
							cc_q     <= cc_q + 1'b1;
							unread_q <= to_link(e_q);
						end
					end
				end
				S_CM_NW: begin
					if (rd.status == ST_READING) begin
						if (!item_q.aband) sts_q <= STS_BLOCKED;
						else rc_q <= cnt_dec(rc_q);
					end else begin
						rc_q <= cnt_dec(rc_q);
						cc_q <= cc_q + 1'b1;
					end
				end
				S_CM_UR: begin
					if (rd.older == to_link(e_q)) unread_q <= to_link(e_q);
				end
				S_RM_F: begin
					if (f_q == e_q) begin
						newest_q <= LINK_NIL;
						oldest_q <= LINK_NIL;
						unread_q <= LINK_NIL;
						wc_q     <= '0;
						cc_q     <= '0;
						rc_q     <= '0;
					end
				end
				S_RM_W: begin
					if (unread_q == to_link(e_q)) unread_q <= nw_q;
					if (is_nil(od_q)) oldest_q <= nw_q;
					else if (is_nil(nw_q)) newest_q <= od_q;
				end
				default: begin
				end
			endcase
		end
	end

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> wr.mask == '0)
		else $error("table written while idle");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DISPATCH)
		else $error("accepted beat not dispatched");

	a_free_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RF |-> cnt_q != '0)
		else $error("reclaim free loop ran past its run");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped before taken");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench of the variable record ring allocator: random and directed stream beats.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import vrra_pkg::*;

	localparam int NIL = -1;
	localparam int QUIET_LIMIT = 40000;

	class ring_tracker;
		int nxt[SLOTS], prv[SLOTS], newer[SLOTS], older[SLOTS], elen[SLOTS];
		ent_st_t est[SLOTS];
		bit written[SLOTS];
		int newest, oldest, unread, wcnt, ccnt, rcnt, cap;
		res_t expected_results[$];
		int errors;

		function new();
			foreach (written[i]) written[i] = 0;
			clear_lists();
			cap = 4096;
			errors = 0;
		endfunction

		function int cost(int l);
			return ((HEADER_BYTES + l + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
		endfunction

		function int usable();
			return cap > REGION_BYTES ? REGION_BYTES : cap;
		endfunction

		function void clear_lists();
			newest = NIL; oldest = NIL; unread = NIL;
			wcnt = 0; ccnt = 0; rcnt = 0;
		endfunction

		function void set_writing(int e, int l);
			est[e] = ST_WRITING;
			elen[e] = l;
			written[e] = 1;
			wcnt++;
		endfunction

		function void make_single(int e, int l);
			nxt[e] = e; prv[e] = e; newer[e] = NIL; older[e] = NIL;
			set_writing(e, l);
			newest = e; oldest = e; unread = e;
		endfunction

		function void append_newest(int e);
			newer[e] = NIL;
			older[e] = newest;
			if (newest != NIL) newer[newest] = e;
			newest = e;
		endfunction

		function void insert_after_newest(int e, int l);
			int f;
			f = nxt[newest];
			set_writing(e, l);
			nxt[e] = f; prv[e] = newest; prv[f] = e; nxt[newest] = e;
			append_newest(e);
			if (unread == NIL) unread = e;
		endfunction

		function bit reclaim(int l, int need, output int where);
			int u, b, start, fin, lost, span, n, k, ne, s_older, e_next, e_newer;
			u = unread;
			where = 0;
			if (u == NIL || est[u] != ST_COMMITTED) return 0;
			if (nxt[u] == u) begin
				if (usable() < need) return 0;
				est[u] = ST_FREE;
				clear_lists();
				make_single(0, l);
				return 1;
			end
			b = prv[u];
			start = (b < u) ? b * ALIGN_BYTES + cost(elen[b]) : 0;
			fin = u;
			lost = 1;
			forever begin
				span = fin * ALIGN_BYTES + cost(elen[fin]);
				span = span > start ? span - start : 0;
				n = nxt[fin];
				if (!(span < need && est[n] == ST_COMMITTED && n == newer[fin] && n > fin))
					break;
				fin = n;
				lost++;
			end
			if (span < need) return 0;
			e_next = nxt[fin]; s_older = older[u]; e_newer = newer[fin];
			k = u;
			for (int i = 0; i < lost; i++) begin
				n = nxt[k];
				est[k] = ST_FREE;
				k = n;
			end
			ne = start / ALIGN_BYTES;
			if (e_next == u) begin
				nxt[ne] = ne; prv[ne] = ne;
			end else begin
				nxt[ne] = e_next; prv[e_next] = ne; prv[ne] = b; nxt[b] = ne;
			end
			if (s_older != NIL) newer[s_older] = e_newer;
			if (e_newer != NIL) older[e_newer] = s_older;
			else newest = s_older;
			append_newest(ne);
			if (s_older == NIL) oldest = (e_newer != NIL) ? e_newer : ne;
			unread = (e_newer != NIL) ? e_newer : ne;
			ccnt = ccnt > lost ? ccnt - lost : 0;
			set_writing(ne, l);
			where = ne;
			return 1;
		endfunction

		function bit place(int l, bit over, output int where);
			int need, h, f, np, gap;
			need = cost(l);
			where = 0;
			if (oldest == NIL) begin
				if (need > usable()) return 0;
				make_single(0, l);
				return 1;
			end
			h = newest;
			f = nxt[h];
			np = h * ALIGN_BYTES + cost(elen[h]);
			if (f > h) begin
				gap = f * ALIGN_BYTES > np ? f * ALIGN_BYTES - np : 0;
				if (gap >= need) begin
					where = np / ALIGN_BYTES;
					insert_after_newest(where, l);
					return 1;
				end
				return over ? reclaim(l, need, where) : 0;
			end
			if (usable() >= np && usable() - np >= need) begin
				where = np / ALIGN_BYTES;
				insert_after_newest(where, l);
				return 1;
			end
			if (f * ALIGN_BYTES >= need) begin
				insert_after_newest(0, l);
				return 1;
			end
			return over ? reclaim(l, need, where) : 0;
		endfunction

		function void remove_entry(int e);
			int nx, pv, nw, od;
			nx = nxt[e]; pv = prv[e]; nw = newer[e]; od = older[e];
			est[e] = ST_FREE;
			if (nx == e) begin
				clear_lists();
				return;
			end
			nxt[pv] = nx; prv[nx] = pv;
			if (od != NIL) newer[od] = nw;
			if (nw != NIL) older[nw] = od;
			if (unread == e) unread = nw;
			if (od == NIL) oldest = nw;
			else if (nw == NIL) newest = od;
		endfunction

		function sts_t finish_commit(int e, bit disc, bit aband);
			int nw;
			if (est[e] == ST_WRITING) begin
				wcnt = wcnt ? wcnt - 1 : 0;
				if (disc) remove_entry(e);
				else begin
					ccnt++;
					est[e] = ST_COMMITTED;
				end
				return STS_OK;
			end
			if (!disc) begin
				rcnt = rcnt ? rcnt - 1 : 0;
				remove_entry(e);
				return STS_OK;
			end
			nw = newer[e];
			if (nw != NIL && est[nw] == ST_READING) begin
				if (!aband) return STS_BLOCKED;
				rcnt = rcnt ? rcnt - 1 : 0;
				remove_entry(e);
				return STS_OK;
			end
			rcnt = rcnt ? rcnt - 1 : 0;
			ccnt++;
			est[e] = ST_COMMITTED;
			if (nw == NIL) unread = e;
			else if (unread != NIL && older[unread] == e) unread = e;
			return STS_OK;
		endfunction

		function void note_op(kind_t k, int l, bit over, bit disc, bit aband, int hd);
			res_t r;
			int e;
			r.status = STS_OK; r.handle = '0; r.length = '0;
			if (k == KIND_RESERVE) begin
				if (place(l, over, e)) begin
					r.handle = hnd_t'(e * ALIGN_BYTES);
					r.length = len_t'(l);
				end else r.status = STS_NO_ROOM;
			end else if (k == KIND_CONSUME) begin
				e = unread;
				if (e == NIL || est[e] != ST_COMMITTED) r.status = STS_EMPTY;
				else begin
					ccnt = ccnt ? ccnt - 1 : 0;
					rcnt++;
					unread = newer[e];
					est[e] = ST_READING;
					r.handle = hnd_t'(e * ALIGN_BYTES);
					r.length = len_t'(elen[e]);
				end
			end else if (k == KIND_COMMIT) begin
				e = hd / ALIGN_BYTES;
				if (hd % ALIGN_BYTES != 0 || e >= SLOTS || est[e] == ST_FREE ||
				    est[e] == ST_COMMITTED) r.status = STS_BAD_HANDLE;
				else begin
					r.handle = hnd_t'(hd);
					r.length = len_t'(elen[e]);
					r.status = finish_commit(e, disc, aband);
				end
			end
			r.wc = cnt_t'(wcnt); r.cc = cnt_t'(ccnt); r.rc = cnt_t'(rcnt);
			expected_results.push_back(r);
		endfunction

		task report(string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_result(logic [63:0] d);
			res_t x;
			if (expected_results.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			x = expected_results.pop_front();
			if (d[2:0] !== x.status)
				report($sformatf("status %0d, want %0d", d[2:0], x.status));
			if (d[14:3] !== x.handle)
				report($sformatf("record_handle %0d, want %0d", d[14:3], x.handle));
			if (d[27:15] !== x.length)
				report($sformatf("record_length %0d, want %0d", d[27:15], x.length));
			if (d[37:28] !== x.wc)
				report($sformatf("writing_count %0d, want %0d", d[37:28], x.wc));
			if (d[47:38] !== x.cc)
				report($sformatf("committed_count %0d, want %0d", d[47:38], x.cc));
			if (d[57:48] !== x.rc)
				report($sformatf("reading_count %0d, want %0d", d[57:48], x.rc));
		endtask

		// live: writing or reading entries; otherwise any entry ever written
		function int pick(bit live);
			int cand[$];
			for (int i = 0; i < SLOTS; i++)
				if (written[i] && (!live || est[i] == ST_WRITING || est[i] == ST_READING))
					cand.push_back(i);
			if (cand.size() == 0) return NIL;
			return cand[$urandom_range(cand.size() - 1)];
		endfunction

		function int first_in_age(ent_st_t s);
			for (int e = oldest; e != NIL; e = newer[e])
				if (est[e] == s) return e;
			return NIL;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [63:0] m_tdata;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	ring_tracker tracker = new();
	int src_idle = 0, snk_stall = 0, quiet = 0;

	always #5 clk = ~clk;

	variable_record_ring_allocator u_dut (.*);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tready <= 0;
		else m_tready <= ($urandom_range(99) >= snk_stall);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) tracker.check_result(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("variable_record_ring_allocator test failed");
				$finish;
			end
		end
	end

	task automatic send(kind_t k, int l, bit over, bit disc, bit aband, int hd);
		if ($urandom_range(99) < src_idle) begin
			s_tvalid <= 0;
			do @(posedge clk); while ($urandom_range(99) < src_idle);
		end
		s_tvalid <= 1;
		s_tuser <= k;
		s_tdata <= {4'b0, hnd_t'(hd), aband, disc, over, len_t'(l)};
		do @(posedge clk); while (!s_tready);
		tracker.note_op(k, l, over, disc, aband, hd);
	endtask

	task automatic write_capacity(int v);
		s_tvalid <= 0;
		wait (tracker.expected_results.size() == 0);
		repeat (40) @(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= 3'(REG_CAPACITY * 4); pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		tracker.cap = v & 'h1FFF;
	endtask

	task automatic commit_of(int e, bit disc, bit aband);
		send(KIND_COMMIT, $urandom_range(4096), 1'($urandom_range(1)), disc, aband,
		     e == NIL ? 5 : e * ALIGN_BYTES);
	endtask

	task automatic random_op();
		int p, l, e, hd;
		p = $urandom_range(99);
		l = ($urandom_range(9) < 7) ? $urandom_range(200) :
		    ($urandom_range(9) < 8) ? $urandom_range(1500) : $urandom_range(4096);
		if (p < 36) send(KIND_RESERVE, l, 1'($urandom_range(1)), 1'($urandom_range(1)),
		                 1'($urandom_range(1)), $urandom_range(4095));
		else if (p < 57) send(KIND_CONSUME, l, 1'($urandom_range(1)), 1'($urandom_range(1)),
		                      1'($urandom_range(1)), $urandom_range(4095));
		else if (p < 59) send(kind_t'(2'd3), l, 1'($urandom_range(1)), 1'($urandom_range(1)),
		                      1'($urandom_range(1)), $urandom_range(4095));
		else begin
			p = $urandom_range(99);
			e = tracker.pick(p < 80);
			if (p >= 92 || e == NIL)
				hd = $urandom_range(511) * ALIGN_BYTES + $urandom_range(1, 7);
			else hd = e * ALIGN_BYTES;
			send(KIND_COMMIT, l, 1'($urandom_range(1)), $urandom_range(9) < 2,
			     1'($urandom_range(1)), hd);
		end
	endtask

	task automatic run_phase(int cap, int idle, int stall, int n);
		write_capacity(cap);
		src_idle = idle;
		snk_stall = stall;
		repeat (n) random_op();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_capacity(4096);

		send(KIND_CONSUME, 0, 0, 0, 0, 0);
		send(KIND_COMMIT, 0, 0, 0, 0, 'hFFF);
		send(KIND_RESERVE, 0, 0, 0, 0, 0);
		send(KIND_RESERVE, 4096, 0, 0, 0, 0);
		commit_of(tracker.first_in_age(ST_WRITING), 0, 0);
		send(KIND_RESERVE, 100, 0, 0, 0, 0);
		commit_of(tracker.first_in_age(ST_WRITING), 0, 0);
		send(KIND_CONSUME, 0, 0, 0, 0, 0);
		send(KIND_CONSUME, 0, 0, 0, 0, 0);
		commit_of(tracker.first_in_age(ST_READING), 1, 0);
		commit_of(tracker.first_in_age(ST_READING), 1, 1);
		commit_of(tracker.first_in_age(ST_READING), 1, 0);
		send(KIND_COMMIT, 0, 0, 0, 0, 0);
		send(KIND_RESERVE, 300, 0, 0, 0, 0);
		commit_of(tracker.first_in_age(ST_WRITING), 1, 0);
		send(kind_t'(2'd3), 4096, 1, 1, 1, 'hFFF);
		repeat (4) begin
			send(KIND_RESERVE, 1000, 0, 0, 0, 0);
			commit_of(tracker.first_in_age(ST_WRITING), 0, 0);
		end
		send(KIND_RESERVE, 1000, 1, 0, 0, 0);
		send(KIND_RESERVE, 4095, 1, 0, 0, 0);
		send(KIND_CONSUME, 0, 0, 0, 0, 0);
		commit_of(tracker.first_in_age(ST_READING), 0, 0);

		run_phase(4096, 0, 0, 350);
		run_phase(8191, 61, 0, 350);
		run_phase(600, 0, 61, 350);
		run_phase(0, 33, 33, 100);
		run_phase($urandom_range(1000, 4096), 33, 33, 300);
		s_tvalid <= 0;
		wait (tracker.expected_results.size() == 0);
		repeat (60) @(posedge clk);
		if (tracker.errors == 0 && tracker.expected_results.size() == 0)
			$display("variable_record_ring_allocator test passed");
		else
			$display("variable_record_ring_allocator test failed");
		$finish;
	end
endmodule
